[rtl/acoll_pkg.sv]
// ----------------------------------------------------------------------------
// acoll_pkg
// shared types and constants of the acknowledgement collection table
// ----------------------------------------------------------------------------
package acoll_pkg;

   localparam int ROWS_DEFAULT  = 32;
   localparam int GROUP_DEFAULT = 4;
   localparam int MAX_RESULTS   = 32;
   localparam int ZOMBIE_AGE    = 2;

   localparam int PID_W  = 22;
   localparam int MSG_W  = 16;
   localparam int TIME_W = 32;
   localparam int STEP_W = 16;
   localparam int CNT_W  = 6;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_QUERY = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;
   localparam logic [1:0] FUNC_SWEEP = 2'd3;

   localparam logic [1:0] KIND_ADD    = 2'd0;
   localparam logic [1:0] KIND_QUERY  = 2'd1;
   localparam logic [1:0] KIND_REPORT = 2'd2;

   typedef struct packed {
      logic [MSG_W-1:0]  msg;
      logic [PID_W-1:0]  snd;
      logic [PID_W-1:0]  rcv;
      logic [TIME_W-1:0] tim;
      logic              zom;
      logic [STEP_W-1:0] zstep;
   } row_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic              flag;
      logic [MSG_W-1:0]  msg;
      logic [PID_W-1:0]  snd;
      logic [PID_W-1:0]  rcv;
      logic [TIME_W-1:0] tim;
      logic              glast;
      logic              slast;
   } result_type;

endpackage

[rtl/ack_collection_table_core.sv]
// ----------------------------------------------------------------------------
// ack_collection_table_core
// table of acknowledgement rows with add, query, tick and sweep commands
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid/req_ready   | func, pids, message, time
//  rsp     | out       | rsp_valid/rsp_ready   | kind, flag, report row, lasts
//
//  one transaction at a time; rows live in a two-bank memory, one read a cycle
//  add: scan for the first free row, then the result; query: read and compare
//  every row, then the result; sweep: sort passes copy live rows by falling message
//  into the other bank, then rows are scanned and groups reported; tick: steps the counter
//  reset clears valid bits, step counter and output; no memory clearing pass
//  a stalled rsp channel holds the sequencer at the next result
// ----------------------------------------------------------------------------
module ack_collection_table_core
   import acoll_pkg::*;
#(
   parameter int ROWS  = ROWS_DEFAULT,
   parameter int GROUP = GROUP_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_func,
   input  logic [PID_W-1:0]  req_sender_pid,
   input  logic [PID_W-1:0]  req_receiver_pid,
   input  logic [MSG_W-1:0]  req_message_number,
   input  logic [TIME_W-1:0] req_time_stamp,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_result_kind,
   output logic              rsp_status_flag,
   output logic [MSG_W-1:0]  rsp_report_message,
   output logic [PID_W-1:0]  rsp_report_sender,
   output logic [PID_W-1:0]  rsp_report_receiver,
   output logic [TIME_W-1:0] rsp_report_time,
   output logic              rsp_group_last,
   output logic              rsp_sweep_last
);

   localparam int AW = $clog2(ROWS);
   localparam int PW = $clog2(ROWS + 1);
   localparam int IW = $clog2(ROWS + GROUP + 1);
   localparam logic [AW-1:0] LAST = AW'(ROWS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_ADD, S_QRD, S_QCMP, S_SRD, S_SCMP, S_SPUT,
      S_VRD, S_VCHK, S_RRD, S_RPUT, S_FIN, S_OUT
   } state_type;

   state_type         state_ff;
   logic [ROWS-1:0]   valid_ff;
   logic [ROWS-1:0]   taken_ff;
   logic              bank_ff;
   logic [STEP_W-1:0] step_ff;
   logic [AW-1:0]     idx_ff;
   logic [PW-1:0]     pos_ff;
   logic [IW-1:0]     i_ff;
   logic [AW-1:0]     rep_ff;
   logic [PW-1:0]     streak_ff;
   logic              have_ff;
   logic [MSG_W-1:0]  cur_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              best_found_ff;
   logic [AW-1:0]     best_idx_ff;
   row_type           best_ff;
   row_type           new_ff;
   logic [1:0]        func_ff;
   logic              flag_ff;
   result_type        pend_ff;
   logic              pend_valid_ff;
   result_type        out_ff;
   logic              out_valid_ff;

   row_type           mem [2**(AW+1)];
   row_type           rdata_ff;
   logic [AW:0]       raddr;
   logic              mem_we;
   logic [AW:0]       mem_waddr;
   row_type           mem_wdata;

   logic              out_free;
   logic              rep_go;
   logic [PW-1:0]     streak_in;
   logic              zombie_old;
   logic [STEP_W-1:0] zage;
   result_type        rep_row;
   logic              out_load;
   result_type        out_in;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign rep_go    = !pend_valid_ff || out_free;
   assign req_ready = (state_ff == S_IDLE);

   assign zage       = step_ff - rdata_ff.zstep;
   assign zombie_old = rdata_ff.zom && (zage >= STEP_W'(ZOMBIE_AGE));
   assign streak_in  = (have_ff && rdata_ff.msg == cur_ff) ? streak_ff + PW'(1) : PW'(1);

   always_comb begin
      rep_row       = '0;
      rep_row.kind  = KIND_REPORT;
      rep_row.msg   = rdata_ff.msg;
      rep_row.snd   = rdata_ff.snd;
      rep_row.rcv   = rdata_ff.rcv;
      rep_row.tim   = rdata_ff.tim;
      rep_row.glast = (IW'(rep_ff) == i_ff);
   end

   always_comb begin
      out_load = 1'b0;
      out_in   = pend_ff;
      unique case (state_ff)
         S_RPUT: out_load = rep_go && pend_valid_ff;
         S_FIN: begin
            out_load     = pend_valid_ff && out_free;
            out_in.slast = 1'b1;
         end
         S_OUT: begin
            out_load    = out_free;
            out_in      = '0;
            out_in.kind = (func_ff == FUNC_ADD) ? KIND_ADD : KIND_QUERY;
            out_in.flag = flag_ff;
         end
         default: out_load = 1'b0;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         S_QRD, S_QCMP, S_SRD, S_SCMP: raddr = {bank_ff, idx_ff};
         S_VRD, S_VCHK:                raddr = {bank_ff, i_ff[AW-1:0]};
         S_RRD, S_RPUT:                raddr = {bank_ff, rep_ff};
         default:                      raddr = '0;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {bank_ff, idx_ff};
      mem_wdata = new_ff;
      if (state_ff == S_ADD && !valid_ff[idx_ff]) begin
         mem_we = 1'b1;
      end else if (state_ff == S_SPUT && best_found_ff) begin
         mem_we    = 1'b1;
         mem_waddr = {~bank_ff, pos_ff[AW-1:0]};
         mem_wdata = best_ff;
      end else if (state_ff == S_RPUT && rep_go) begin
         mem_we          = 1'b1;
         mem_waddr       = {bank_ff, rep_ff};
         mem_wdata       = rdata_ff;
         mem_wdata.zom   = 1'b1;
         mem_wdata.zstep = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         taken_ff      <= '0;
         bank_ff       <= 1'b0;
         step_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         if (out_load) begin
            out_ff       <= out_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  func_ff     <= req_func;
                  new_ff.msg  <= req_message_number;
                  new_ff.snd  <= req_sender_pid;
                  new_ff.rcv  <= req_receiver_pid;
                  new_ff.tim  <= req_time_stamp;
                  new_ff.zom  <= 1'b0;
                  new_ff.zstep <= '0;
                  idx_ff      <= '0;
                  flag_ff     <= 1'b0;
                  unique case (req_func)
                     FUNC_ADD:   state_ff <= S_ADD;
                     FUNC_QUERY: state_ff <= S_QRD;
                     FUNC_TICK:  step_ff  <= step_ff + STEP_W'(1);
                     FUNC_SWEEP: begin
                        taken_ff      <= '0;
                        pos_ff        <= '0;
                        best_found_ff <= 1'b0;
                        state_ff      <= S_SRD;
                     end
                  endcase
               end
            end
            S_ADD: begin
               if (!valid_ff[idx_ff]) begin
                  valid_ff[idx_ff] <= 1'b1;
                  flag_ff          <= 1'b1;
                  state_ff         <= S_OUT;
               end else if (idx_ff == LAST) begin
                  state_ff <= S_OUT;
               end else begin
                  idx_ff <= idx_ff + AW'(1);
               end
            end
            S_QRD: state_ff <= S_QCMP;
            S_QCMP: begin
               if (valid_ff[idx_ff] && rdata_ff.rcv == new_ff.rcv
                   && rdata_ff.msg == new_ff.msg) begin
                  flag_ff <= 1'b1;
               end
               if (idx_ff == LAST) begin
                  state_ff <= S_OUT;
               end else begin
                  idx_ff   <= idx_ff + AW'(1);
                  state_ff <= S_QRD;
               end
            end
            S_SRD: state_ff <= S_SCMP;
            S_SCMP: begin
               if (valid_ff[idx_ff] && !taken_ff[idx_ff]
                   && (!best_found_ff || rdata_ff.msg > best_ff.msg)) begin
                  best_found_ff <= 1'b1;
                  best_idx_ff   <= idx_ff;
                  best_ff       <= rdata_ff;
               end
               if (idx_ff == LAST) begin
                  state_ff <= S_SPUT;
               end else begin
                  idx_ff   <= idx_ff + AW'(1);
                  state_ff <= S_SRD;
               end
            end
            S_SPUT: begin
               idx_ff <= '0;
               if (best_found_ff) begin
                  taken_ff[best_idx_ff] <= 1'b1;
                  pos_ff                <= pos_ff + PW'(1);
                  best_found_ff         <= 1'b0;
                  state_ff              <= S_SRD;
               end else begin
                  for (int j = 0; j < ROWS; j++) begin
                     valid_ff[j] <= (PW'(j) < pos_ff);
                  end
                  bank_ff   <= ~bank_ff;
                  i_ff      <= '0;
                  streak_ff <= '0;
                  have_ff   <= 1'b0;
                  cnt_ff    <= '0;
                  state_ff  <= S_VRD;
               end
            end
            S_VRD: begin
               if (i_ff >= IW'(ROWS)) begin
                  state_ff <= S_FIN;
               end else if (!valid_ff[i_ff[AW-1:0]]) begin
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= S_VCHK;
               end
            end
            S_VCHK: begin
               if (zombie_old) begin
                  for (int j = 0; j < ROWS; j++) begin
                     if (IW'(j) >= i_ff && IW'(j) < i_ff + IW'(GROUP)) begin
                        valid_ff[j] <= 1'b0;
                     end
                  end
                  i_ff      <= i_ff + IW'(GROUP);
                  have_ff   <= 1'b0;
                  streak_ff <= '0;
                  state_ff  <= S_VRD;
               end else begin
                  have_ff   <= 1'b1;
                  cur_ff    <= rdata_ff.msg;
                  streak_ff <= streak_in;
                  if (32'(streak_in) == GROUP && 32'(cnt_ff) + GROUP <= MAX_RESULTS) begin
                     rep_ff   <= i_ff[AW-1:0] - AW'(GROUP - 1);
                     state_ff <= S_RRD;
                  end else begin
                     i_ff     <= i_ff + IW'(1);
                     state_ff <= S_VRD;
                  end
               end
            end
            S_RRD: state_ff <= S_RPUT;
            S_RPUT: begin
               if (rep_go) begin
                  pend_ff       <= rep_row;
                  pend_valid_ff <= 1'b1;
                  cnt_ff        <= cnt_ff + CNT_W'(1);
                  if (IW'(rep_ff) == i_ff) begin
                     i_ff     <= i_ff + IW'(1);
                     state_ff <= S_VRD;
                  end else begin
                     rep_ff   <= rep_ff + AW'(1);
                     state_ff <= S_RRD;
                  end
               end
            end
            S_FIN: begin
               if (!pend_valid_ff) begin
                  state_ff <= S_IDLE;
               end else if (out_free) begin
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_result_kind     = out_ff.kind;
   assign rsp_status_flag     = out_ff.flag;
   assign rsp_report_message  = out_ff.msg;
   assign rsp_report_sender   = out_ff.snd;
   assign rsp_report_receiver = out_ff.rcv;
   assign rsp_report_time     = out_ff.tim;
   assign rsp_group_last      = out_ff.glast;
   assign rsp_sweep_last      = out_ff.slast;

endmodule

[rtl/acoll_checker.sv]
// ----------------------------------------------------------------------------
// acoll_checker
// port level checks of the acknowledgement collection table
// ----------------------------------------------------------------------------
module acoll_checker
   import acoll_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_func,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_result_kind,
   input logic       rsp_status_flag,
   input logic       rsp_group_last,
   input logic       rsp_sweep_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp transaction dropped while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func != FUNC_TICK |=> !req_ready)
      else $error("new transaction taken while one is in progress");

   a_lasts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_REPORT |-> !rsp_group_last && !rsp_sweep_last)
      else $error("last marks on a non-report result");

   a_sweep_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sweep_last |-> rsp_group_last && rsp_result_kind == KIND_REPORT)
      else $error("sweep ended inside a group");

   a_report_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_REPORT |-> !rsp_status_flag)
      else $error("status flag set on a report row");

endmodule

bind ack_collection_table_core acoll_checker u_acoll_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_func        (req_func),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_kind (rsp_result_kind),
   .rsp_status_flag (rsp_status_flag),
   .rsp_group_last  (rsp_group_last),
   .rsp_sweep_last  (rsp_sweep_last)
);

[test/ack_collection_table_core_tb.sv]
// ----------------------------------------------------------------------------
// ack_collection_table_core_tb
// directed and random check of the ack table core: add, query, tick and sweep
// transactions are driven with random gaps, every response is compared with
// a table model or a directed flag, and the response side stalls at random
// ----------------------------------------------------------------------------
module ack_collection_table_core_tb
   import acoll_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NROWS      = ROWS_DEFAULT;
   localparam int NGROUP     = GROUP_DEFAULT;
   localparam int N_RANDOM   = 310;
   localparam int IDLE_LIMIT = 40000;
   localparam int DRAIN      = 3000;

   typedef struct {
      logic [1:0]        func;
      logic [PID_W-1:0]  snd;
      logic [PID_W-1:0]  rcv;
      logic [MSG_W-1:0]  msg;
      logic [TIME_W-1:0] tim;
      bit                typed;
      logic              flag;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_func = FUNC_TICK;
   logic [PID_W-1:0]  req_sender_pid = '0;
   logic [PID_W-1:0]  req_receiver_pid = '0;
   logic [MSG_W-1:0]  req_message_number = '0;
   logic [TIME_W-1:0] req_time_stamp = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_result_kind;
   logic              rsp_status_flag;
   logic [MSG_W-1:0]  rsp_report_message;
   logic [PID_W-1:0]  rsp_report_sender;
   logic [PID_W-1:0]  rsp_report_receiver;
   logic [TIME_W-1:0] rsp_report_time;
   logic              rsp_group_last;
   logic              rsp_sweep_last;

   // table model
   logic              tbl_valid [NROWS];
   logic [PID_W-1:0]  tbl_snd   [NROWS];
   logic [PID_W-1:0]  tbl_rcv   [NROWS];
   logic [MSG_W-1:0]  tbl_msg   [NROWS];
   logic [TIME_W-1:0] tbl_tim   [NROWS];
   logic              tbl_zom   [NROWS];
   logic [STEP_W-1:0] tbl_zstep [NROWS];
   logic [STEP_W-1:0] tbl_step;

   result_type   pending_rsp[$];
   stim_row_type directed[$];
   int           mismatches = 0;
   int           idle_cycles = 0;
   bit           no_idle = 1'b0;

   ack_collection_table_core u_dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void clear_entry(int i);
      tbl_valid[i] = 1'b0;
      tbl_snd[i]   = '0;
      tbl_rcv[i]   = '0;
      tbl_msg[i]   = '0;
      tbl_tim[i]   = '0;
      tbl_zom[i]   = 1'b0;
      tbl_zstep[i] = '0;
   endfunction

   function automatic result_type mk_result(logic [1:0] kind, logic flag);
      result_type r;
      r = '0;
      r.kind = kind;
      r.flag = flag;
      return r;
   endfunction

   function automatic void sort_table();
      logic [PID_W-1:0]  b_snd [NROWS];
      logic [PID_W-1:0]  b_rcv [NROWS];
      logic [MSG_W-1:0]  b_msg [NROWS];
      logic [TIME_W-1:0] b_tim [NROWS];
      logic              b_zom [NROWS];
      logic [STEP_W-1:0] b_zst [NROWS];
      int n, j;
      n = 0;
      for (int i = 0; i < NROWS; i++) begin
         if (tbl_valid[i]) begin
            j = n;
            while (j > 0 && b_msg[j-1] < tbl_msg[i]) begin
               b_snd[j] = b_snd[j-1];
               b_rcv[j] = b_rcv[j-1];
               b_msg[j] = b_msg[j-1];
               b_tim[j] = b_tim[j-1];
               b_zom[j] = b_zom[j-1];
               b_zst[j] = b_zst[j-1];
               j--;
            end
            b_snd[j] = tbl_snd[i];
            b_rcv[j] = tbl_rcv[i];
            b_msg[j] = tbl_msg[i];
            b_tim[j] = tbl_tim[i];
            b_zom[j] = tbl_zom[i];
            b_zst[j] = tbl_zstep[i];
            n++;
         end
      end
      for (int i = 0; i < NROWS; i++) begin
         if (i < n) begin
            tbl_valid[i] = 1'b1;
            tbl_snd[i]   = b_snd[i];
            tbl_rcv[i]   = b_rcv[i];
            tbl_msg[i]   = b_msg[i];
            tbl_tim[i]   = b_tim[i];
            tbl_zom[i]   = b_zom[i];
            tbl_zstep[i] = b_zst[i];
         end else begin
            clear_entry(i);
         end
      end
   endfunction

   function automatic void sweep_table(ref result_type res[$]);
      int cnt, streak, i;
      bit have;
      logic [MSG_W-1:0] cur;
      logic [STEP_W-1:0] age;
      result_type r;
      cnt = 0; streak = 0; i = 0; have = 1'b0; cur = '0;
      sort_table();
      while (i < NROWS && tbl_valid[i]) begin
         age = tbl_step - tbl_zstep[i];
         if (tbl_zom[i] && age >= ZOMBIE_AGE) begin
            for (int k = 0; k < NGROUP && i + k < NROWS; k++) clear_entry(i + k);
            i += NGROUP;
            have = 1'b0;
            streak = 0;
         end else begin
            if (have && tbl_msg[i] == cur) begin
               streak++;
            end else begin
               cur = tbl_msg[i];
               have = 1'b1;
               streak = 1;
            end
            if (streak == NGROUP && cnt + NGROUP <= MAX_RESULTS) begin
               for (int k = i - NGROUP + 1; k <= i; k++) begin
                  r = mk_result(KIND_REPORT, 1'b0);
                  r.msg   = tbl_msg[k];
                  r.snd   = tbl_snd[k];
                  r.rcv   = tbl_rcv[k];
                  r.tim   = tbl_tim[k];
                  r.glast = (k == i);
                  res.push_back(r);
                  cnt++;
                  tbl_zom[k]   = 1'b1;
                  tbl_zstep[k] = tbl_step;
               end
            end
            i++;
         end
      end
      if (cnt > 0) res[cnt-1].slast = 1'b1;
   endfunction

   function automatic void predict_table(stim_row_type s, ref result_type res[$]);
      bit done;
      logic found;
      res.delete();
      case (s.func)
         FUNC_ADD: begin
            done = 1'b0;
            for (int i = 0; i < NROWS && !done; i++) begin
               if (!tbl_valid[i]) begin
                  tbl_valid[i] = 1'b1;
                  tbl_snd[i]   = s.snd;
                  tbl_rcv[i]   = s.rcv;
                  tbl_msg[i]   = s.msg;
                  tbl_tim[i]   = s.tim;
                  tbl_zom[i]   = 1'b0;
                  tbl_zstep[i] = '0;
                  done = 1'b1;
               end
            end
            res.push_back(mk_result(KIND_ADD, done));
         end
         FUNC_QUERY: begin
            found = 1'b0;
            for (int i = 0; i < NROWS; i++)
               if (tbl_valid[i] && tbl_rcv[i] == s.rcv && tbl_msg[i] == s.msg) found = 1'b1;
            res.push_back(mk_result(KIND_QUERY, found));
         end
         FUNC_TICK: tbl_step = tbl_step + 1'b1;
         default: sweep_table(res);
      endcase
   endfunction

   task automatic send_transaction(stim_row_type s);
      int gap;
      result_type res[$];
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_func           <= s.func;
      req_sender_pid     <= s.snd;
      req_receiver_pid   <= s.rcv;
      req_message_number <= s.msg;
      req_time_stamp     <= s.tim;
      req_valid          <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_table(s, res);
      if (s.typed) begin
         pending_rsp.push_back(mk_result(s.func == FUNC_ADD ? KIND_ADD : KIND_QUERY, s.flag));
      end else begin
         foreach (res[k]) pending_rsp.push_back(res[k]);
      end
   endtask

   function automatic stim_row_type mk_stim(logic [1:0] f, logic [PID_W-1:0] snd,
                                            logic [PID_W-1:0] rcv, logic [MSG_W-1:0] msg,
                                            logic [TIME_W-1:0] tim, bit typed, logic flag);
      stim_row_type s;
      s.func = f; s.snd = snd; s.rcv = rcv; s.msg = msg; s.tim = tim;
      s.typed = typed; s.flag = flag;
      return s;
   endfunction

   function automatic stim_row_type random_stim(ref logic [MSG_W-1:0] burst_msg,
                                                ref int burst_left);
      stim_row_type s;
      int r;
      s = mk_stim(FUNC_TICK, PID_W'($urandom), PID_W'($urandom), MSG_W'($urandom),
                  $urandom, 1'b0, 1'b0);
      if ($urandom_range(0, 3) != 0) s.rcv = PID_W'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) s.rcv[PID_W-1 -: 3] = 3'b111;
      if (burst_left > 0) begin
         s.func = FUNC_ADD;
         s.msg  = burst_msg;
         burst_left--;
         return s;
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
         burst_msg  = ($urandom_range(0, 5) == 0) ? MSG_W'($urandom)
                                                   : MSG_W'($urandom_range(1, 6));
         burst_left = NGROUP - 1 + (($urandom_range(0, 3) == 0) ? 1 : 0);
         s.func = FUNC_ADD;
         s.msg  = burst_msg;
      end else if (r < 40) begin
         s.func = FUNC_ADD;
         if ($urandom_range(0, 2) != 0) s.msg = MSG_W'($urandom_range(0, 8));
      end else if (r < 60) begin
         s.func = FUNC_QUERY;
         if ($urandom_range(0, 2) != 0) s.msg = MSG_W'($urandom_range(0, 8));
      end else if (r < 78) begin
         s.func = FUNC_TICK;
      end else begin
         s.func = FUNC_SWEEP;
      end
      return s;
   endfunction

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got.kind  = rsp_result_kind;
         got.flag  = rsp_status_flag;
         got.msg   = rsp_report_message;
         got.snd   = rsp_report_sender;
         got.rcv   = rsp_report_receiver;
         got.tim   = rsp_report_time;
         got.glast = rsp_group_last;
         got.slast = rsp_sweep_last;
         if (pending_rsp.size() == 0) begin
            if (mismatches < 10) $display("unexpected response %p", got);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            if (got.kind !== want.kind || got.flag !== want.flag || got.msg !== want.msg ||
                got.snd !== want.snd || got.rcv !== want.rcv || got.tim !== want.tim ||
                got.glast !== want.glast || got.slast !== want.slast) begin
               if (mismatches < 10) $display("mismatch: expected %p actual %p", want, got);
               mismatches++;
            end
         end
      end
   end

   // response side stalls
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      stim_row_type s;
      logic [MSG_W-1:0] burst_msg;
      int burst_left;
      burst_msg = '0;
      burst_left = 0;
      for (int i = 0; i < NROWS; i++) clear_entry(i);
      tbl_step = '0;

      directed.push_back(mk_stim(FUNC_QUERY, '0, '0, 16'd1, '0, 1'b1, 1'b0));
      directed.push_back(mk_stim(FUNC_SWEEP, '0, '0, '0, '0, 1'b0, 1'b0));
      directed.push_back(mk_stim(FUNC_ADD, '0, '0, 16'hFFFF, '0, 1'b1, 1'b1));
      directed.push_back(mk_stim(FUNC_ADD, '1, '1, 16'hFFFF, '1, 1'b1, 1'b1));
      directed.push_back(mk_stim(FUNC_ADD, 22'h2AAAAA, 22'h155555, 16'hFFFF,
                                 32'hA5A5A5A5, 1'b1, 1'b1));
      directed.push_back(mk_stim(FUNC_QUERY, '0, '1, 16'hFFFF, '0, 1'b1, 1'b1));
      directed.push_back(mk_stim(FUNC_QUERY, '0, '1, 16'hFFFE, '0, 1'b1, 1'b0));
      directed.push_back(mk_stim(FUNC_SWEEP, '0, '0, '0, '0, 1'b0, 1'b0));
      directed.push_back(mk_stim(FUNC_ADD, 22'h155555, 22'h2AAAAA, 16'hFFFF,
                                 32'h5A5A5A5A, 1'b1, 1'b1));
      directed.push_back(mk_stim(FUNC_ADD, 22'd7, 22'd9, 16'd0, 32'd3, 1'b1, 1'b1));
      directed.push_back(mk_stim(FUNC_SWEEP, '0, '0, '0, '0, 1'b0, 1'b0));
      directed.push_back(mk_stim(FUNC_SWEEP, '0, '0, '0, '0, 1'b0, 1'b0));
      directed.push_back(mk_stim(FUNC_TICK, '0, '0, '0, '0, 1'b0, 1'b0));
      directed.push_back(mk_stim(FUNC_SWEEP, '0, '0, '0, '0, 1'b0, 1'b0));
      directed.push_back(mk_stim(FUNC_TICK, '1, '1, '1, '1, 1'b0, 1'b0));
      directed.push_back(mk_stim(FUNC_SWEEP, '0, '0, '0, '0, 1'b0, 1'b0));
      directed.push_back(mk_stim(FUNC_QUERY, '0, '1, 16'hFFFF, '0, 1'b0, 1'b0));
      directed.push_back(mk_stim(FUNC_QUERY, '0, 22'd9, 16'd0, '0, 1'b0, 1'b0));
      directed.push_back(mk_stim(FUNC_SWEEP, '0, '0, '0, '0, 1'b0, 1'b0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) send_transaction(directed[k]);
      for (int n = 0; n < N_RANDOM; n++) begin
         if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
         s = random_stim(burst_msg, burst_left);
         send_transaction(s);
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
